/* src/ifdm_pkg.sv */
// ============================================================================
// ifdm_pkg: shared types, constants and functions
// Frame layout codes, channel qualification limits and the duty mapping used
// by the serial frame to dual motor drive block.
// ============================================================================
package ifdm_pkg;

    // Frame structure
    localparam logic [7:0]  SYNC_FIRST  = 8'h20;
    localparam logic [7:0]  SYNC_SECOND = 8'h40;
    localparam logic [15:0] SUM_START   = 16'hff9f;
    localparam logic [4:0]  POS_IDLE    = 5'd30;

    // Channel qualification limits (in the low 12 bits of a channel word)
    localparam logic [11:0] WIDTH_MIN   = 12'd800;
    localparam logic [11:0] WIDTH_MAX   = 12'd2200;
    localparam logic [11:0] CENTRE_LO   = 12'd1450;
    localparam logic [11:0] CENTRE_HI   = 12'd1550;
    localparam logic [12:0] CENTRE      = 13'd1500;

    // Drive mapping limits
    localparam logic signed [11:0] DEADBAND  = 12'sd50;
    localparam logic signed [11:0] MAG_LIMIT = 12'sd500;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CHAN_A      = 3'd0,
        REG_CHAN_B      = 3'd1,
        REG_INDEPENDENT = 3'd2,
        REG_DUTY_FLOOR  = 3'd3,
        REG_DUTY_CEIL   = 3'd4
    } t_reg_idx;

    // Signed command of one channel, -700..700
    typedef logic signed [10:0] t_cmd;
    // Signed motor command after mixing, -1400..1400
    typedef logic signed [11:0] t_mix;

    typedef struct packed {
        logic armed;
        t_cmd cmd;
    } t_qual;

    typedef struct packed {
        logic [15:0] duty;
        logic        fwd;
        logic        rev;
    } t_drive;

    // Qualify one channel width against the arming rules.
    function automatic t_qual qualify(input logic [11:0] w, input logic armed_in);
        t_qual       q;
        logic [12:0] diff;
        diff    = {1'b0, w} - CENTRE;
        q.armed = armed_in;
        q.cmd   = '0;
        if (w < WIDTH_MIN || w > WIDTH_MAX) begin
            q.armed = 1'b0;
        end else if (armed_in || (w >= CENTRE_LO && w <= CENTRE_HI)) begin
            q.armed = 1'b1;
            q.cmd   = t_cmd'(diff[10:0]);
        end
        return q;
    endfunction

    // Map a signed command to a duty value with direction flags.
    function automatic t_drive drive(input t_mix c, input logic [15:0] floor_v,
                                     input logic [15:0] ceil_v);
        t_drive     d;
        t_mix       mag;
        logic [11:0] excess;
        d.fwd  = (c > DEADBAND);
        d.rev  = (c < -DEADBAND);
        mag    = d.rev ? -c : c;
        excess = 12'(mag - DEADBAND);
        if (mag < DEADBAND) begin
            d.duty = '0;
        end else if (mag > MAG_LIMIT) begin
            d.duty = ceil_v;
        end else begin
            d.duty = floor_v + {4'b0, excess};
        end
        return d;
    endfunction

endpackage

/* src/ibus_frame_to_dual_motor_drive_top.sv */
// ============================================================================
// ibus_frame_to_dual_motor_drive_top: serial frame receiver and motor drive
// Parses 32-byte channel frames, qualifies two channels and maps them to two
// PWM duty values with direction flags.
// ============================================================================
// Usage
//   Input channel: one received byte per transfer on i_rx_byte, handshake
//   i_rx_valid / o_rx_ready. The byte pair 0x20 0x40 starts a frame at any
//   point; 14 channel words and a checksum follow.
//   Output channel: one transfer per frame whose checksum matches, carrying
//   both duty values and the four direction flags, handshake o_out_valid /
//   i_out_ready.
//   Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_we is
//   high; only while no byte is in flight.
//   Path: a byte is held in the input register and processed from there into
//   the result register, so the last checksum byte's result is offered from
//   there. Throughput is one byte per cycle unless a result stalls, set by
//   the single parse stage between the input and result registers.
//   Reset: synchronous, active low. The parser goes idle, both channels are
//   disarmed with commands at zero and the configuration registers reset.
//   Stall: while a result waits, further bytes are still taken and parsed; only
//   a second result behind a waiting one holds the input register and drops
//   o_rx_ready until the first is transferred.
// ============================================================================
module ibus_frame_to_dual_motor_drive_top
    import ifdm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // byte input channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_duty_one,
    output logic [15:0] o_duty_two,
    output logic        o_fwd_one,
    output logic        o_rev_one,
    output logic        o_fwd_two,
    output logic        o_rev_two
);

    // Configuration registers
    logic [3:0]  r_chan_a;
    logic [3:0]  r_chan_b;
    logic        r_indep;
    logic [15:0] r_duty_floor;
    logic [15:0] r_duty_ceil;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state
    logic [7:0]  r_cur,   n_cur;
    logic [4:0]  r_pos,   n_pos;
    logic [15:0] r_sum,   n_sum;
    logic        r_arm_a, n_arm_a;
    logic        r_arm_b, n_arm_b;
    t_cmd        r_cmd_a, n_cmd_a;
    t_cmd        r_cmd_b, n_cmd_b;

    // Result register
    logic        r_out_valid;
    t_drive      r_drv_one, n_drv_one;
    t_drive      r_drv_two, n_drv_two;

    logic        sync_hit;
    logic        in_frame;
    logic [4:0]  pos_inc;
    logic [15:0] word;
    logic [8:0]  byte_sum;
    logic [3:0]  slot;
    logic        res_hit;
    logic        advance;
    t_qual       qual_a;
    t_qual       qual_b;
    t_mix        mix_one;
    t_mix        mix_two;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_a     <= 4'd1;
            r_chan_b     <= 4'd2;
            r_indep      <= 1'b0;
            r_duty_floor <= 16'd50;
            r_duty_ceil  <= 16'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHAN_A:      r_chan_a     <= i_cfg_wdata[3:0];
                REG_CHAN_B:      r_chan_b     <= i_cfg_wdata[3:0];
                REG_INDEPENDENT: r_indep      <= i_cfg_wdata[0];
                REG_DUTY_FLOOR:  r_duty_floor <= i_cfg_wdata;
                REG_DUTY_CEIL:   r_duty_ceil  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame decode of the byte held in the input register
    always_comb begin
        sync_hit = (r_cur == SYNC_FIRST) && (r_in_byte == SYNC_SECOND);
        in_frame = (r_pos < POS_IDLE);
        pos_inc  = r_pos + 5'd1;
        word     = {r_in_byte, r_cur};
        byte_sum = {1'b0, r_cur} + {1'b0, r_in_byte};
        slot     = pos_inc[4:1];
        res_hit  = !sync_hit && in_frame && (pos_inc == POS_IDLE) && (r_sum == word);
        qual_a   = qualify(word[11:0], r_arm_a);
        qual_b   = qualify(word[11:0], r_arm_b);
        advance  = r_in_valid && (!res_hit || !r_out_valid || i_out_ready);
    end

    // Next parser state
    always_comb begin
        n_cur   = r_in_byte;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_arm_a = r_arm_a;
        n_arm_b = r_arm_b;
        n_cmd_a = r_cmd_a;
        n_cmd_b = r_cmd_b;
        if (sync_hit) begin
            n_pos = '0;
            n_sum = SUM_START;
        end else if (in_frame) begin
            n_pos = pos_inc;
            // Channel words complete on even positions short of the checksum
            if (!pos_inc[0] && pos_inc != POS_IDLE) begin
                if (r_chan_a == slot) begin
                    n_arm_a = qual_a.armed;
                    n_cmd_a = qual_a.cmd;
                end
                if (r_chan_b == slot) begin
                    n_arm_b = qual_b.armed;
                    n_cmd_b = qual_b.cmd;
                end
                n_sum = r_sum - {7'b0, byte_sum};
            end
        end
    end

    // Motor mixing and duty mapping
    always_comb begin
        if (r_indep) begin
            mix_one = {r_cmd_a[10], r_cmd_a};
            mix_two = {r_cmd_b[10], r_cmd_b};
        end else begin
            mix_one = {r_cmd_a[10], r_cmd_a} + {r_cmd_b[10], r_cmd_b};
            mix_two = {r_cmd_a[10], r_cmd_a} - {r_cmd_b[10], r_cmd_b};
        end
        n_drv_one = drive(mix_one, r_duty_floor, r_duty_ceil);
        n_drv_two = drive(mix_two, r_duty_floor, r_duty_ceil);
    end

    // Input register: refilled whenever it is empty or being processed
    assign o_rx_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_pos   <= POS_IDLE;
            r_sum   <= '0;
            r_arm_a <= 1'b0;
            r_arm_b <= 1'b0;
            r_cmd_a <= '0;
            r_cmd_b <= '0;
        end else if (advance) begin
            r_cur   <= n_cur;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_arm_a <= n_arm_a;
            r_arm_b <= n_arm_b;
            r_cmd_a <= n_cmd_a;
            r_cmd_b <= n_cmd_b;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_hit) begin
            r_drv_one <= n_drv_one;
            r_drv_two <= n_drv_two;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty_one  = r_drv_one.duty;
    assign o_fwd_one   = r_drv_one.fwd;
    assign o_rev_one   = r_drv_one.rev;
    assign o_duty_two  = r_drv_two.duty;
    assign o_fwd_two   = r_drv_two.fwd;
    assign o_rev_two   = r_drv_two.rev;

endmodule

/* src/ifdm_chk.sv */
// ============================================================================
// ifdm_chk: port checker for the frame to motor drive block
// Watches the top level's ports for reset, stall and result timing rules.
// ============================================================================
module ifdm_chk
    import ifdm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_duty_one,
    input logic [15:0] o_duty_two,
    input logic        o_fwd_one,
    input logic        o_rev_one,
    input logic        o_fwd_two,
    input logic        o_rev_two
);

    // A waiting result stays offered until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_duty_one) && $stable(o_duty_two) &&
            $stable({o_fwd_one, o_rev_one, o_fwd_two, o_rev_two}))
        else $error("stalled result payload changed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // A new result only follows the transfer of the byte that completed it,
    // which passes through the input register first.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_rx_valid && o_rx_ready, 2))
        else $error("result appeared without a preceding byte transfer");

    // Direction flags of one motor exclude each other.
    a_dir_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_fwd_one && o_rev_one) && !(o_fwd_two && o_rev_two))
        else $error("forward and reverse both set");

endmodule

bind ibus_frame_to_dual_motor_drive_top ifdm_chk u_ifdm_chk (.*);
